// ===== hdl/lfu_pkg.sv =====
// lfu_pkg: shared types and constants for the LFU cache table.
// No dependencies; imported by lfu_cache_table.
package lfu_pkg;

  localparam int CAP_BITS          = 5;
  localparam int CAP_RESET         = 16;
  localparam int ENTRIES_DEFAULT   = 16;
  localparam int KEY_BITS_DEFAULT  = 32;
  localparam int VALUE_BITS_DEFAULT = 32;
  localparam int COUNT_BITS_DEFAULT = 16;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_SET = 1'b1
  } opcode_t;

endpackage

// ===== hdl/lfu_cache_table.sv =====
// lfu_cache_table: key/value table with LFU replacement, LRU tie break.
// Depends on lfu_pkg (opcode type, capacity width and reset value).
//
//  channel | dir | tdata (low bit up)          | tuser (low bit up)
//  --------+-----+-----------------------------+--------------------
//  in_     | in  | key, value, zero pad        | opcode
//  out_    | out | read_data, evicted_key, pad | hit, evicted
//  cfg_    | in  | capacity (write only)       | -
//
// One transaction per cycle unless out_ stalls; out_tvalid rises once a
// request has passed the request and result registers. Match, LFU/LRU victim
// select and rank update run between them; table state updates there. A
// stalled out_ holds its result and parks at most one request in the request
// register. Reset clears valid bits and fill count; capacity is 16.
module lfu_cache_table #(
  parameter int ENTRIES    = lfu_pkg::ENTRIES_DEFAULT,
  parameter int KEY_BITS   = lfu_pkg::KEY_BITS_DEFAULT,
  parameter int VALUE_BITS = lfu_pkg::VALUE_BITS_DEFAULT,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEFAULT,
  localparam int IN_DW     = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8,
  localparam int OUT_DW    = ((VALUE_BITS + KEY_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [lfu_pkg::CAP_BITS-1:0]  cfg_wr_data,   // capacity
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [IN_DW-1:0]              in_tdata,      // key, value
  input  lfu_pkg::opcode_t              in_tuser,      // opcode
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [OUT_DW-1:0]             out_tdata,     // read_data, evicted_key
  output logic [1:0]                    out_tuser      // hit, evicted
);
  import lfu_pkg::*;

  localparam int AW   = $clog2(ENTRIES);
  localparam int UW   = $clog2(ENTRIES + 1);
  localparam int CMPW = ((UW > CAP_BITS) ? UW : CAP_BITS) + 1;
  localparam int RW   = COUNT_BITS + AW;

  // request register
  logic                  req_v_r;
  opcode_t               req_op_r;
  logic [KEY_BITS-1:0]   req_key_r;
  logic [VALUE_BITS-1:0] req_val_r;

  // result register
  logic                  out_v_r;
  logic                  out_hit_r;
  logic                  out_ev_r;
  logic [VALUE_BITS-1:0] out_rd_r;
  logic [KEY_BITS-1:0]   out_evk_r;

  // table state
  logic [CAP_BITS-1:0]   cap_r;
  logic [UW-1:0]         used_r, used_nxt;
  logic [ENTRIES-1:0]    valid_r, valid_nxt;
  logic [KEY_BITS-1:0]   ent_key_r [ENTRIES];
  logic [VALUE_BITS-1:0] ent_val_r [ENTRIES];
  logic [COUNT_BITS-1:0] ent_cnt_r [ENTRIES];
  logic [AW-1:0]         ent_age_r [ENTRIES];
  logic [KEY_BITS-1:0]   key_nxt [ENTRIES];
  logic [VALUE_BITS-1:0] val_nxt [ENTRIES];
  logic [COUNT_BITS-1:0] cnt_nxt [ENTRIES];
  logic [AW-1:0]         age_nxt [ENTRIES];

  logic                  fire;
  logic                  is_set;
  logic [ENTRIES-1:0]    match;
  logic [ENTRIES-1:0]    victim_oh;
  logic [ENTRIES-1:0]    free_vec;
  logic [ENTRIES-1:0]    slot_oh;
  logic [RW-1:0]         rank [ENTRIES];
  logic                  hit;
  logic                  full;
  logic                  do_ins;
  logic                  do_evict;
  logic [AW-1:0]         hit_age;
  logic [AW-1:0]         vic_age;
  logic [VALUE_BITS-1:0] hit_val;
  logic [KEY_BITS-1:0]   vic_key;
  logic [CMPW-1:0]       cap_eff;

  assign fire      = req_v_r && (!out_v_r || out_tready);
  assign in_tready = !req_v_r || fire;
  assign is_set    = (req_op_r == OP_SET);

  // capacity clamp to 1..ENTRIES
  always_comb begin
    cap_eff = CMPW'(cap_r);
    if (cap_eff == '0) begin
      cap_eff = CMPW'(1);
    end else if (cap_eff > CMPW'(ENTRIES)) begin
      cap_eff = CMPW'(ENTRIES);
    end
  end

  assign full = CMPW'(used_r) >= cap_eff;

  // key match and victim select (pairwise rank compare)
  for (genvar i = 0; i < ENTRIES; i++) begin : g_ent
    logic [ENTRIES-1:0] beats;
    assign match[i] = valid_r[i] && (ent_key_r[i] == req_key_r);
    assign rank[i]  = {ent_cnt_r[i], ~ent_age_r[i]};
    for (genvar j = 0; j < ENTRIES; j++) begin : g_cmp
      if (i == j) begin : g_self
        assign beats[j] = 1'b1;
      end else begin : g_other
        assign beats[j] = !valid_r[j] || (rank[i] < rank[j]);
      end
    end
    assign victim_oh[i] = valid_r[i] && (&beats);
  end

  always_comb begin
    hit_age = '0;
    vic_age = '0;
    hit_val = '0;
    vic_key = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_age = hit_age | (match[i] ? ent_age_r[i] : '0);
      hit_val = hit_val | (match[i] ? ent_val_r[i] : '0);
      vic_age = vic_age | (victim_oh[i] ? ent_age_r[i] : '0);
      vic_key = vic_key | (victim_oh[i] ? ent_key_r[i] : '0);
    end
  end

  assign hit      = |match;
  assign do_ins   = is_set && !hit;
  assign do_evict = do_ins && full;
  assign free_vec = ~(valid_r & ~(do_evict ? victim_oh : '0));
  assign slot_oh  = free_vec & (~free_vec + ENTRIES'(1));

  // next table state
  always_comb begin
    valid_nxt = valid_r;
    used_nxt  = used_r;
    for (int i = 0; i < ENTRIES; i++) begin
      key_nxt[i] = ent_key_r[i];
      val_nxt[i] = ent_val_r[i];
      cnt_nxt[i] = ent_cnt_r[i];
      age_nxt[i] = ent_age_r[i];
    end
    if (fire) begin
      if (hit) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (match[i]) begin
            age_nxt[i] = '0;
            if (ent_cnt_r[i] != '1) begin
              cnt_nxt[i] = ent_cnt_r[i] + COUNT_BITS'(1);
            end
            if (is_set) begin
              val_nxt[i] = req_val_r;
            end
          end else if (valid_r[i] && (ent_age_r[i] < hit_age)) begin
            age_nxt[i] = ent_age_r[i] + AW'(1);
          end
        end
      end else if (do_ins) begin
        if (!do_evict) begin
          used_nxt = used_r + UW'(1);
        end
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_oh[i]) begin
            valid_nxt[i] = 1'b1;
            key_nxt[i]   = req_key_r;
            val_nxt[i]   = req_val_r;
            cnt_nxt[i]   = COUNT_BITS'(1);
            age_nxt[i]   = '0;
          end else if (do_evict && victim_oh[i]) begin
            valid_nxt[i] = 1'b0;
          end else if (valid_r[i] && !(do_evict && (ent_age_r[i] > vic_age))) begin
            age_nxt[i] = ent_age_r[i] + AW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_BITS'(CAP_RESET);
      used_r  <= '0;
      valid_r <= '0;
      req_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      used_r  <= used_nxt;
      valid_r <= valid_nxt;
      if (in_tvalid && in_tready) begin
        req_v_r <= 1'b1;
      end else if (fire) begin
        req_v_r <= 1'b0;
      end
      if (fire) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      ent_key_r[i] <= key_nxt[i];
      ent_val_r[i] <= val_nxt[i];
      ent_cnt_r[i] <= cnt_nxt[i];
      ent_age_r[i] <= age_nxt[i];
    end
    if (in_tvalid && in_tready) begin
      req_op_r  <= in_tuser;
      req_key_r <= in_tdata[KEY_BITS-1:0];
      req_val_r <= in_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
    end
    if (fire) begin
      out_hit_r <= hit;
      out_rd_r  <= (hit && !is_set) ? hit_val : '0;
      out_ev_r  <= do_evict;
      out_evk_r <= do_evict ? vic_key : '0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = {out_ev_r, out_hit_r};
  assign out_tdata  = OUT_DW'({out_evk_r, out_rd_r});

  // fill count tracks the valid bits
  a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
    used_r == UW'($countones(valid_r)))
    else $error("fill count out of step with valid bits");

  // at most one entry matches, at most one victim
  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match) && $onehot0(victim_oh))
    else $error("duplicate key match or victim");

  // a nonempty table always yields a victim
  a_victim_found: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r != '0) |-> (victim_oh != '0))
    else $error("no victim in nonempty table");

  // hit and eviction are exclusive
  a_hit_ev: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(out_hit_r && out_ev_r))
    else $error("hit and eviction together");

  // an eviction (set miss at capacity) leaves the fill count unchanged
  a_ev_full: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && do_evict) |=> (used_r == $past(used_r)))
    else $error("eviction changed fill count");

endmodule
